/* hw/rtl/bdq_pkg.sv */
// Shared types and constants for the bounded double-ended queue.
`timescale 1ns / 1ps
package bdq_pkg;

	// Fixed field widths of the request and response beats.
	localparam int unsigned VALUE_W   = 32;
	localparam int unsigned FUNC_W    = 3;
	localparam int unsigned ERR_W     = 2;
	localparam int unsigned COUNT_W   = 5;
	localparam int unsigned CAP_W     = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// Operation codes carried in the func field.
	typedef enum logic [FUNC_W-1:0] {
		FUNC_PUSH_BACK  = 3'd0,
		FUNC_PUSH_FRONT = 3'd1,
		FUNC_POP_BACK   = 3'd2,
		FUNC_POP_FRONT  = 3'd3,
		FUNC_PEEK_FRONT = 3'd4,
		FUNC_PEEK_BACK  = 3'd5,
		FUNC_CLEAR      = 3'd6
	} bdq_func_t;

	// Error codes reported in the response.
	localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
	localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
	localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

	// Request beat.
	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [VALUE_W-1:0] value_in;
	} bdq_req_t;

	// Response beat.
	typedef struct packed {
		logic               ok;
		logic [VALUE_W-1:0] value_out;
		logic [ERR_W-1:0]   error_code;
		logic [COUNT_W-1:0] count;
		logic               is_empty;
		logic               is_full;
	} bdq_rsp_t;

	// Access the controller requests from the entry memory this cycle.
	typedef struct packed {
		logic wr;
		logic rd;
	} bdq_mem_cmd_t;

	// Status of one operation, produced by the controller.
	typedef struct packed {
		logic               ok;
		logic               rd_sel;
		logic [ERR_W-1:0]   error_code;
		logic [COUNT_W-1:0] count;
		logic               is_empty;
		logic               is_full;
	} bdq_status_t;

endpackage

/* hw/rtl/bdq_store.sv */
// Entry memory of the deque: one write or one read per cycle, registered read data.
`timescale 1ns / 1ps
module bdq_store #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned WIDTH = 32
) (
	input  logic                     clk,
	input  bdq_pkg::bdq_mem_cmd_t    cmd,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	import bdq_pkg::*;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem_q[addr] <= wdata;
		end
	end

	// Read port with output register.
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/bdq_ctrl.sv */
// Deque controller: head, count and capacity registers and the per-operation decode.
`timescale 1ns / 1ps
module bdq_ctrl #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [bdq_pkg::CAP_W-1:0]   cfg_wdata,
	input  logic                        valid,
	input  logic [bdq_pkg::FUNC_W-1:0]  func,
	output bdq_pkg::bdq_mem_cmd_t       mem_cmd,
	output logic [$clog2(DEPTH)-1:0]    mem_addr,
	output bdq_pkg::bdq_status_t        status
);
	import bdq_pkg::*;

	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned SUM_W = IDX_W + 1;
	localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	logic [IDX_W-1:0] head_q, head_nxt;
	logic [CNT_W-1:0] count_q, count_nxt;
	logic [CAP_W-1:0] capacity_q;

	logic [CMP_W-1:0] eff_cap, count_ext;
	logic             full, empty;
	logic [SUM_W-1:0] back_sum, last_sum;
	logic [IDX_W-1:0] back_idx, last_idx, head_dec, head_inc;

	// Capacity register; the user must write it only while idle, the block itself does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	// Effective capacity saturates at the ring depth.
	always_comb begin
		if (CMP_W'(capacity_q) > CMP_W'(DEPTH)) begin
			eff_cap = CMP_W'(DEPTH);
		end else begin
			eff_cap = CMP_W'(capacity_q);
		end
	end

	assign count_ext = CMP_W'(count_q);
	assign full      = count_ext >= eff_cap;
	assign empty     = (count_q == '0);

	// Ring positions: the slot after the back, the back itself, and the
	// neighbors of the front. Sums stay below twice the depth, so one
	// compare and subtract wraps them.
	assign back_sum = SUM_W'(head_q) + SUM_W'(count_q);
	assign last_sum = back_sum - SUM_W'(1);
	assign back_idx = (back_sum >= SUM_W'(DEPTH)) ?
		IDX_W'(back_sum - SUM_W'(DEPTH)) : IDX_W'(back_sum);
	assign last_idx = (last_sum >= SUM_W'(DEPTH)) ?
		IDX_W'(last_sum - SUM_W'(DEPTH)) : IDX_W'(last_sum);
	assign head_dec = (head_q == '0) ? IDX_W'(DEPTH - 1) : head_q - IDX_W'(1);
	assign head_inc = (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + IDX_W'(1);

	// Decode of one operation against the current state.
	always_comb begin
		head_nxt          = head_q;
		count_nxt         = count_q;
		mem_cmd           = '0;
		mem_addr          = head_q;
		status.ok         = 1'b0;
		status.rd_sel     = 1'b0;
		status.error_code = ERR_NONE;
		if (valid) begin
			unique case (func)
				FUNC_PUSH_BACK, FUNC_PUSH_FRONT: begin
					if (full) begin
						status.error_code = ERR_FULL;
					end else begin
						status.ok  = 1'b1;
						mem_cmd.wr = 1'b1;
						count_nxt  = count_q + CNT_W'(1);
						if (func == FUNC_PUSH_BACK) begin
							mem_addr = back_idx;
						end else begin
							mem_addr = head_dec;
							head_nxt = head_dec;
						end
					end
				end
				FUNC_POP_BACK, FUNC_POP_FRONT, FUNC_PEEK_FRONT, FUNC_PEEK_BACK: begin
					if (empty) begin
						status.error_code = ERR_EMPTY;
					end else begin
						status.ok     = 1'b1;
						status.rd_sel = 1'b1;
						mem_cmd.rd    = 1'b1;
						if (func == FUNC_POP_BACK || func == FUNC_PEEK_BACK) begin
							mem_addr = last_idx;
						end
						if (func == FUNC_POP_BACK) begin
							count_nxt = count_q - CNT_W'(1);
						end else if (func == FUNC_POP_FRONT) begin
							count_nxt = count_q - CNT_W'(1);
							head_nxt  = head_inc;
						end
					end
				end
				FUNC_CLEAR: begin
					status.ok = 1'b1;
					head_nxt  = '0;
					count_nxt = '0;
				end
				default: begin
					// Undefined code: no operation, status reports the state.
				end
			endcase
		end
		// Status after the operation.
		status.count    = COUNT_W'(count_nxt);
		status.is_empty = (count_nxt == '0);
		status.is_full  = CMP_W'(count_nxt) >= eff_cap;
	end

	// Ring pointer and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			head_q  <= head_nxt;
			count_q <= count_nxt;
		end
	end

endmodule

/* hw/rtl/bounded_deque_core.sv */
// Top level of the bounded double-ended queue core.
//
//  Channel   Signals                     Direction  Transfer
//  request   start, busy, req            in         start high, busy low
//  response  done, rsp                   out        done high, one cycle
//  config    cfg_we, cfg_wdata           in         cfg_we high
//
// A request beat is registered at the accepting edge, decoded against the
// ring state in the next cycle, and its response is driven from the result
// register and the memory read register in the cycle after that.
// One beat is taken every cycle; busy stays low.
// The single-port entry memory sets that figure: each operation makes at
// most one read or one write, so consecutive beats never contend for it.
// Reset empties the deque and sets the capacity to 16; the entries stay
// undefined until written. The receiver cannot stall, so nothing holds the pipeline.
`timescale 1ns / 1ps
module bounded_deque_core #(
	parameter int unsigned DEPTH      = 16,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  bdq_pkg::bdq_req_t         req,
	output logic                      done,
	output bdq_pkg::bdq_rsp_t         rsp,
	input  logic                      cfg_we,
	input  logic [bdq_pkg::CAP_W-1:0] cfg_wdata
);
	import bdq_pkg::*;

	localparam int unsigned IDX_W   = $clog2(DEPTH);
	localparam int unsigned STORE_W = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;

	logic              valid_s1;
	bdq_req_t          req_s1;
	bdq_mem_cmd_t      mem_cmd;
	logic [IDX_W-1:0]  mem_addr;
	logic [STORE_W-1:0] mem_rdata;
	bdq_status_t       status;
	logic              valid_s2;
	bdq_status_t       status_s2;

	assign busy = 1'b0;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= req;
		end
	end

	bdq_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.valid    (valid_s1),
		.func     (req_s1.func),
		.mem_cmd  (mem_cmd),
		.mem_addr (mem_addr),
		.status   (status)
	);

	bdq_store #(
		.DEPTH(DEPTH),
		.WIDTH(STORE_W)
	) u_store (
		.clk  (clk),
		.cmd  (mem_cmd),
		.addr (mem_addr),
		.wdata(req_s1.value_in[STORE_W-1:0]),
		.rdata(mem_rdata)
	);

	// Result register, aligned with the memory read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			status_s2 <= status;
		end
	end

	// Response beat.
	assign done           = valid_s2;
	assign rsp.ok         = status_s2.ok;
	assign rsp.value_out  = status_s2.rd_sel ? VALUE_W'(mem_rdata) : '0;
	assign rsp.error_code = status_s2.error_code;
	assign rsp.count      = status_s2.count;
	assign rsp.is_empty   = status_s2.is_empty;
	assign rsp.is_full    = status_s2.is_full;

	// A successful beat never carries an error code.
	a_ok_no_error: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(rsp.ok && rsp.error_code != ERR_NONE))
		else $error("successful response carries an error code");

	// A failed push leaves the deque full.
	a_full_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.error_code == ERR_FULL) |-> (rsp.is_full && !rsp.ok))
		else $error("full error reported while not full");

	// A failed pop or peek leaves the deque empty.
	a_empty_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.error_code == ERR_EMPTY) |-> (rsp.is_empty && !rsp.ok))
		else $error("empty error reported while entries are held");

	// An accepted request is answered with done once it has passed the input register and the result register.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("response missing two cycles after acceptance");

endmodule
